// ===== design/jff_pkg.sv =====
package jff_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_END   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_LOADING = 2'd0,
    STAT_DONE    = 2'd1,
    STAT_ERROR   = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    PH_SEEK_STAR   = 4'd0,
    PH_COMMAND     = 4'd1,
    PH_SKIP_Q      = 4'd2,
    PH_SWALLOW     = 4'd3,
    PH_DEV_DIGITS  = 4'd4,
    PH_ADDR_DIGITS = 4'd5,
    PH_FUSE_LIST   = 4'd6,
    PH_DONE        = 4'd7,
    PH_FAILED      = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CS_CLEAR = 2'd0,
    CS_IDLE  = 2'd1,
    CS_READ  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic clr_wr;
    logic rd_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

  localparam logic [1:0] FV_INTACT = 2'd0;
  localparam logic [1:0] FV_EMPTY  = 2'd2;

  localparam logic [13:0] FUSES_SMALL = 14'd2048;
  localparam logic [13:0] FUSES_LARGE = 14'd3200;
  localparam logic [13:0] ADDR_MAX    = 14'h3FFF;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_Q    = 8'h51;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (c >= CH_ZERO && c <= CH_NINE) ? d[3:0] : 4'd0;
  endfunction

  function automatic logic [1:0] status_of(input phase_t p);
    return (p == PH_DONE) ? STAT_DONE : ((p == PH_FAILED) ? STAT_ERROR : STAT_LOADING);
  endfunction

endpackage

// ===== design/jff_ctrl.sv =====
module jff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_mode,
  output logic               in_stall,
  input  jff_pkg::dp_stat_t  st,
  output jff_pkg::ctrl_cmd_t cmd
);
  import jff_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != CS_IDLE) || st.out_busy;
    case (state_r)
      CS_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_nxt = CS_IDLE;
      end
      CS_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.take = 1'b1;
          if (in_mode == MODE_START) state_nxt = CS_CLEAR;
          else if (in_mode == MODE_READ) state_nxt = CS_READ;
        end
      end
      CS_READ: begin
        cmd.rd_load = 1'b1;
        state_nxt   = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

// ===== design/jff_datapath.sv =====
module jff_datapath #(
  parameter int MAP_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  jff_pkg::ctrl_cmd_t cmd,
  output jff_pkg::dp_stat_t  st,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_byte_value,
  input  logic [11:0]        in_fuse_index,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [1:0]         out_fuse_value,
  output logic [13:0]        out_device_number
);
  import jff_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);

  logic [1:0]    mem [MAP_DEPTH];
  logic [1:0]    rd_data_r;
  logic          rd_ok_r;
  logic [AW-1:0] clr_cnt_r;
  logic          small_r;

  phase_t        phase_r, phase_nxt;
  logic [1:0]    dcnt_r, dcnt_nxt;
  logic [13:0]   addr_r, addr_nxt;
  logic [13:0]   dev_r, dev_nxt;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [1:0]    out_fval_r;
  logic [13:0]   out_dev_r;

  logic [13:0]   fcnt;
  logic [14:0]   idx_ext;
  logic [14:0]   addr_ext;
  logic          addr_ok;
  logic          idx_ok;
  logic [3:0]    dig;
  logic [17:0]   dev_mac;
  logic [17:0]   addr_mac;
  logic          fuse_we;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [1:0]    mem_wd;
  logic          take_byte;

  assign fcnt      = small_r ? FUSES_SMALL : FUSES_LARGE;
  assign idx_ext   = 15'(in_fuse_index);
  assign addr_ext  = {1'b0, addr_r};
  assign addr_ok   = (addr_ext < {1'b0, fcnt}) && (addr_ext < 15'(MAP_DEPTH));
  assign idx_ok    = (idx_ext < {1'b0, fcnt}) && (idx_ext < 15'(MAP_DEPTH));
  assign dig       = digit_of(in_byte_value);
  assign dev_mac   = 18'(dev_r) * 18'd10 + 18'(dig);
  assign addr_mac  = 18'(addr_r) * 18'd10 + 18'(dig);
  assign take_byte = cmd.take && (in_mode == MODE_BYTE);

  assign st.clr_last = (clr_cnt_r == AW'(MAP_DEPTH - 1));
  assign st.out_busy = out_valid_r && out_stall;

  always_comb begin
    phase_nxt = phase_r;
    dcnt_nxt  = dcnt_r;
    addr_nxt  = addr_r;
    dev_nxt   = dev_r;
    fuse_we   = 1'b0;
    if (cmd.take && in_mode == MODE_START) begin
      phase_nxt = PH_SEEK_STAR;
      dcnt_nxt  = 2'd0;
    end else if (cmd.take && in_mode == MODE_END) begin
      if (phase_r != PH_DONE && phase_r != PH_FAILED) phase_nxt = PH_FAILED;
    end else if (take_byte) begin
      case (phase_r)
        PH_SEEK_STAR: begin
          if (in_byte_value == CH_STAR) phase_nxt = PH_COMMAND;
        end
        PH_COMMAND: begin
          case (in_byte_value)
            CH_Q:       phase_nxt = PH_SKIP_Q;
            CH_G, CH_F: phase_nxt = PH_SWALLOW;
            CH_C, CH_ETX: phase_nxt = PH_DONE;
            CH_D: begin
              dev_nxt   = 14'd0;
              dcnt_nxt  = 2'd0;
              phase_nxt = PH_DEV_DIGITS;
            end
            CH_L: begin
              addr_nxt  = 14'd0;
              dcnt_nxt  = 2'd0;
              phase_nxt = PH_ADDR_DIGITS;
            end
            default: ;
          endcase
        end
        PH_SKIP_Q:  phase_nxt = PH_SEEK_STAR;
        PH_SWALLOW: phase_nxt = PH_COMMAND;
        PH_DEV_DIGITS: begin
          dev_nxt = dev_mac[13:0];
          if (dcnt_r == 2'd3) phase_nxt = PH_COMMAND;
          else dcnt_nxt = dcnt_r + 2'd1;
        end
        PH_ADDR_DIGITS: begin
          addr_nxt = addr_mac[13:0];
          if (dcnt_r == 2'd3) begin
            dcnt_nxt  = 2'd0;
            phase_nxt = PH_FUSE_LIST;
          end else begin
            dcnt_nxt = dcnt_r + 2'd1;
          end
        end
        PH_FUSE_LIST: begin
          if (in_byte_value == CH_ZERO || in_byte_value == CH_ONE) begin
            fuse_we = addr_ok;
            if (addr_r < ADDR_MAX) addr_nxt = addr_r + 14'd1;
          end else if (!is_space(in_byte_value)) begin
            phase_nxt = PH_COMMAND;
          end
        end
        default: ;
      endcase
    end
  end

  assign mem_we = cmd.clr_wr || fuse_we;
  assign mem_wa = cmd.clr_wr ? clr_cnt_r : addr_ext[AW-1:0];
  assign mem_wd = cmd.clr_wr ? FV_EMPTY : {1'b0, in_byte_value[0]};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.take) begin
      rd_data_r <= mem[idx_ext[AW-1:0]];
      rd_ok_r   <= idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK_STAR;
      dcnt_r      <= 2'd0;
      addr_r      <= 14'd0;
      dev_r       <= 14'd0;
      small_r     <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      dcnt_r  <= dcnt_nxt;
      addr_r  <= addr_nxt;
      dev_r   <= dev_nxt;
      if (cfg_we) small_r <= cfg_wdata;
      if (cmd.take && in_mode == MODE_START) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_wr) begin
        clr_cnt_r <= st.clr_last ? '0 : clr_cnt_r + AW'(1);
      end
      if ((cmd.take && in_mode != MODE_READ) || cmd.rd_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_mode != MODE_READ) begin
      out_status_r <= status_of(phase_nxt);
      out_fval_r   <= FV_INTACT;
      out_dev_r    <= dev_nxt;
    end else if (cmd.rd_load) begin
      out_status_r <= status_of(phase_r);
      out_fval_r   <= rd_ok_r ? rd_data_r : FV_EMPTY;
      out_dev_r    <= dev_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_fuse_value    = out_fval_r;
  assign out_device_number = out_dev_r;

endmodule

// ===== design/jedec_fuse_file_parser.sv =====
// A start, file byte or end item gives its result in the cycle after acceptance;
// a fuse read gives its result from the registered map read through the output register.
// Throughput: one file byte or end item per cycle while the output is not stalled; a read
// holds the input stalled while its map word is loaded to the output, and a start item
// holds it stalled while the map is swept to empty. Reset (rst_n low, synchronous)
// clears the parser and runs the same sweep; configuration writes are taken during the sweep.
module jedec_fuse_file_parser #(
  parameter int MAP_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte_value,
  input  logic [11:0] in_fuse_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_fuse_value,
  output logic [13:0] out_device_number
);
  import jff_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  jff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  jff_datapath #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_mode),
    .in_byte_value     (in_byte_value),
    .in_fuse_index     (in_fuse_index),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_fuse_value    (out_fuse_value),
    .out_device_number (out_device_number)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jff_pkg::*;

  localparam int MAP_DEPTH = 4096;
  localparam logic [1:0] FV_BLOWN = 2'd1;
  localparam int N_ROWS = 30;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    stat_t       status;
    logic [1:0]  fuse_value;
    logic [13:0] device_number;
  } fuse_res_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  ch;
    logic [11:0] ix;
    logic        typed;
    stat_t       status;
    logic [1:0]  fuse_value;
    logic [13:0] device_number;
  } load_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [7:0]  in_byte_value;
  logic [11:0] in_fuse_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [1:0]  out_fuse_value;
  logic [13:0] out_device_number;

  jedec_fuse_file_parser #(.MAP_DEPTH(MAP_DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_byte_value    (in_byte_value),
    .in_fuse_index    (in_fuse_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_fuse_value   (out_fuse_value),
    .out_device_number(out_device_number)
  );

  // parser copy
  phase_t      parse_ph;
  logic [1:0]  dig_n;
  logic [13:0] load_addr;
  logic [13:0] dev_code;
  logic [1:0]  fuse_img [MAP_DEPTH];
  bit          small_dev;

  fuse_res_t   awaited_results [$];
  load_row_t   script [N_ROWS];
  int          errs;
  int          n_items;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          last_l;
  fuse_res_t   got_r;
  fuse_res_t   want_r;

  function automatic bit char_blank(input logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int char_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    return 0;
  endfunction

  function automatic void take_char(input logic [7:0] c, input int lim);
    int acc;
    case (parse_ph)
      PH_SEEK_STAR: if (c == CH_STAR) parse_ph = PH_COMMAND;
      PH_COMMAND: begin
        if (!char_blank(c)) begin
          if (c == CH_Q) parse_ph = PH_SKIP_Q;
          else if (c == CH_G || c == CH_F) parse_ph = PH_SWALLOW;
          else if (c == CH_C || c == CH_ETX) parse_ph = PH_DONE;
          else if (c == CH_D) begin
            dev_code = '0;
            dig_n = '0;
            parse_ph = PH_DEV_DIGITS;
          end else if (c == CH_L) begin
            load_addr = '0;
            dig_n = '0;
            parse_ph = PH_ADDR_DIGITS;
          end
        end
      end
      PH_SKIP_Q: parse_ph = PH_SEEK_STAR;
      PH_SWALLOW: parse_ph = PH_COMMAND;
      PH_DEV_DIGITS: begin
        acc = int'(dev_code) * 10 + char_digit(c);
        dev_code = acc[13:0];
        if (dig_n == 2'd3) parse_ph = PH_COMMAND;
        else dig_n = dig_n + 2'd1;
      end
      PH_ADDR_DIGITS: begin
        acc = int'(load_addr) * 10 + char_digit(c);
        load_addr = acc[13:0];
        if (dig_n == 2'd3) begin
          dig_n = '0;
          parse_ph = PH_FUSE_LIST;
        end else begin
          dig_n = dig_n + 2'd1;
        end
      end
      PH_FUSE_LIST: begin
        if (!char_blank(c)) begin
          if (c == CH_ZERO || c == CH_ONE) begin
            if (int'(load_addr) < lim && int'(load_addr) < MAP_DEPTH)
              fuse_img[load_addr] = {1'b0, c[0]};
            if (load_addr != ADDR_MAX) load_addr = load_addr + 14'd1;
          end else begin
            parse_ph = PH_COMMAND;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic fuse_res_t parser_step(input mode_t m, input logic [7:0] c,
                                           input logic [11:0] ix);
    fuse_res_t r;
    int lim;
    lim = small_dev ? int'(FUSES_SMALL) : int'(FUSES_LARGE);
    r.fuse_value = FV_INTACT;
    case (m)
      MODE_START: begin
        for (int i = 0; i < MAP_DEPTH; i++) fuse_img[i] = FV_EMPTY;
        parse_ph = PH_SEEK_STAR;
        dig_n = '0;
      end
      MODE_BYTE: take_char(c, lim);
      MODE_END: if (parse_ph != PH_DONE && parse_ph != PH_FAILED) parse_ph = PH_FAILED;
      default: begin
        if (int'(ix) < lim && int'(ix) < MAP_DEPTH) r.fuse_value = fuse_img[ix];
        else r.fuse_value = FV_EMPTY;
      end
    endcase
    if (parse_ph == PH_DONE) r.status = STAT_DONE;
    else if (parse_ph == PH_FAILED) r.status = STAT_ERROR;
    else r.status = STAT_LOADING;
    r.device_number = dev_code;
    return r;
  endfunction

  task automatic send_item(input mode_t m, input logic [7:0] c, input logic [11:0] ix,
                           input bit typed, input fuse_res_t want);
    fuse_res_t pred;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = m;
    in_byte_value = c;
    in_fuse_index = ix;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = parser_step(m, c, ix);
    awaited_results.push_back(typed ? want : pred);
    n_items++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_item(MODE_BYTE, c, 12'($urandom_range(0, 4095)), 1'b0, '0);
  endtask

  task automatic send_rand_byte();
    send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_blanks(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(8, 13);
      send_byte(r == 8 ? CH_SP : 8'(r));
    end
  endtask

  task automatic send_number(input int v);
    int p;
    p = 1000;
    repeat (4) begin
      if ($urandom_range(0, 9) == 0) send_rand_byte();
      else send_byte(CH_ZERO + 8'((v / p) % 10));
      p = p / 10;
    end
  endtask

  task automatic send_read();
    int r;
    int ix;
    r = $urandom_range(0, 2);
    if (r == 0) ix = last_l + $urandom_range(0, 24);
    else if (r == 1) ix = $urandom_range(0, 4095);
    else begin
      case ($urandom_range(0, 5))
        0: ix = 0;
        1: ix = 2047;
        2: ix = 2048;
        3: ix = 3199;
        4: ix = 3200;
        default: ix = 4095;
      endcase
    end
    send_item(MODE_READ, 8'($urandom_range(0, 255)), ix[11:0], 1'b0, '0);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input bit v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    small_dev = v;
  endtask

  task automatic send_fuse_list();
    int a;
    int r;
    case ($urandom_range(0, 5))
      0, 1: a = $urandom_range(0, 63);
      2: a = $urandom_range(2040, 2056);
      3: a = $urandom_range(3190, 3210);
      4: a = $urandom_range(4088, 4100);
      default: a = $urandom_range(0, 9999);
    endcase
    send_byte(CH_L);
    send_number(a);
    last_l = a;
    repeat ($urandom_range(1, 24)) begin
      r = $urandom_range(0, 9);
      if (r < 4) send_byte(CH_ZERO);
      else if (r < 8) send_byte(CH_ONE);
      else send_blanks(1);
    end
    if ($urandom_range(0, 3) == 0) send_rand_byte();
    else send_byte(CH_STAR);
  endtask

  // one file with random, possibly malformed content, then reads
  task automatic run_file();
    int r;
    send_item(MODE_START, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
              1'b0, '0);
    repeat ($urandom_range(0, 2)) send_rand_byte();
    send_byte(CH_STAR);
    repeat ($urandom_range(2, 7)) begin
      send_blanks($urandom_range(0, 2));
      case ($urandom_range(0, 10))
        0, 1: begin
          send_byte(CH_D);
          send_number($urandom_range(0, 9999));
        end
        2, 3, 4, 5, 6: send_fuse_list();
        7: begin
          send_byte(CH_Q);
          repeat ($urandom_range(1, 5)) send_rand_byte();
          send_byte(CH_STAR);
        end
        8: begin
          send_byte($urandom_range(0, 1) ? CH_G : CH_F);
          send_rand_byte();
        end
        9: send_rand_byte();
        default: repeat ($urandom_range(1, 3)) send_read();
      endcase
    end
    r = $urandom_range(0, 7);
    if (r < 4) send_byte(CH_C);
    else if (r < 6) send_byte(CH_ETX);
    else if (r == 6) send_item(MODE_END, 8'($urandom_range(0, 255)), '0, 1'b0, '0);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) send_rand_byte();
      send_item(MODE_END, '0, 12'($urandom_range(0, 4095)), 1'b0, '0);
    end
    repeat ($urandom_range(1, 6)) send_read();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb NOT OK");
    $finish;
  end

  initial out_stall = 1'b0;
  always @(negedge clk) out_stall = ($urandom_range(0, 99) < rx_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (awaited_results.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected item: status %0d fuse %0d device %0d",
                                 out_status, out_fuse_value, out_device_number);
      end else begin
        want_r = awaited_results.pop_front();
        got_r.status = stat_t'(out_status);
        got_r.fuse_value = out_fuse_value;
        got_r.device_number = out_device_number;
        if (got_r !== want_r) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: expected status %0d fuse %0d device %0d, got %0d %0d %0d",
                     want_r.status, want_r.fuse_value, want_r.device_number,
                     out_status, out_fuse_value, out_device_number);
        end
      end
    end
  end

  initial begin
    errs = 0;
    n_items = 0;
    last_l = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_START;
    in_byte_value = '0;
    in_fuse_index = '0;
    parse_ph = PH_SEEK_STAR;
    dig_n = '0;
    load_addr = '0;
    dev_code = '0;
    small_dev = 1'b0;
    for (int i = 0; i < MAP_DEPTH; i++) fuse_img[i] = FV_EMPTY;

    script = '{
      '{MODE_READ,  8'h00,   12'd0,    1'b1, STAT_LOADING, FV_EMPTY,  14'd0},
      '{MODE_READ,  8'hFF,   12'd4095, 1'b1, STAT_LOADING, FV_EMPTY,  14'd0},
      '{MODE_BYTE,  8'hFF,   12'd0,    1'b1, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_END,   8'h00,   12'hFFF,  1'b1, STAT_ERROR,   FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_STAR, 12'd0,    1'b1, STAT_ERROR,   FV_INTACT, 14'd0},
      '{MODE_START, 8'hFF,   12'hFFF,  1'b1, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_STAR, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_TAB,  12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_D,    12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_NINE, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  "a",     12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_NINE, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_NINE, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_L,    12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  "3",     12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_ONE,  12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_NINE, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_NINE, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_ONE,  12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_ZERO, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_Q,    12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_Q,    12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_G,    12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_STAR, 12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_F,    12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_C,    12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_BYTE,  CH_ETX,  12'd0,    1'b0, STAT_LOADING, FV_INTACT, 14'd0},
      '{MODE_READ,  8'h00,   12'd3199, 1'b1, STAT_DONE,    FV_BLOWN,  14'd9099},
      '{MODE_READ,  8'h00,   12'd3198, 1'b1, STAT_DONE,    FV_EMPTY,  14'd9099},
      '{MODE_END,   8'h00,   12'd0,    1'b1, STAT_DONE,    FV_INTACT, 14'd9099}
    };

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    write_cfg(1'b0);

    for (int i = 0; i < N_ROWS; i++)
      send_item(script[i].mode, script[i].ch, script[i].ix, script[i].typed,
                '{script[i].status, script[i].fuse_value, script[i].device_number});

    for (int ph = 0; ph < 4; ph++) begin
      int base;
      drain();
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
        default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
      endcase
      write_cfg(ph[0]);
      base = n_items;
      while (n_items - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          drain();
          write_cfg(1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 6))
            send_item(mode_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                      12'($urandom_range(0, 4095)), 1'b0, '0);
        run_file();
      end
    end

    drain();
    rx_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (errs == 0 && awaited_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
